/* src/tlvp_pkg.sv */
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types, kind codes and helpers for the TLV stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_OK    = 2'd2;
  localparam logic [1:0] KIND_FAIL  = 2'd3;

  // Header: 4 tag bytes then 4 length bytes
  localparam int unsigned HDR_CNT_W    = 3;
  localparam logic [2:0]  HDR_TAG_LAST = 3'd3;
  localparam logic [2:0]  HDR_LAST     = 3'd7;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_last;
  } tlvp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag;
    logic [31:0] length;
    logic [7:0]  value_byte;
    logic [31:0] byte_offset;
    logic        element_last;
    logic        run_last;
  } tlvp_out_t;

  // One queue entry holds all results of one input item: a first record and
  // an optional trailing status record.
  typedef struct packed {
    tlvp_out_t rec;
    logic      extra_v;
    logic      extra_ok;
  } tlvp_entry_t;

  function automatic tlvp_out_t make_status(input logic ok);
    tlvp_out_t r;
    r              = '0;
    r.kind         = ok ? KIND_OK : KIND_FAIL;
    r.run_last     = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/tlvp_front.sv */
// ----------------------------------------------------------------------------
// tlvp_front
// Accepts bytes, tracks header/value parse state, and pushes the results of
// each byte that has any as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvp_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire tlvp_pkg::tlvp_in_t in_data,
  input  wire                  q_full,
  output logic                 q_push,
  output tlvp_pkg::tlvp_entry_t q_entry
);

  logic                           in_value_r, in_value_nxt;
  logic [tlvp_pkg::HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]                    tag_r, tag_nxt;
  logic [31:0]                    len_r, len_nxt;
  logic [31:0]                    off_r, off_nxt;
  logic                           seen_r, seen_nxt;

  logic                           accept;
  logic                           rec_v;
  logic                           elast;
  tlvp_pkg::tlvp_out_t            rec;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    in_value_nxt = in_value_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    off_nxt      = off_r;
    seen_nxt     = seen_r;
    rec_v        = 1'b0;
    rec          = '0;
    elast        = (off_r == (len_r - 32'd1));

    if (in_value_r) begin
      rec_v            = 1'b1;
      rec.kind         = tlvp_pkg::KIND_VALUE;
      rec.tag          = tag_r;
      rec.length       = len_r;
      rec.value_byte   = in_data.data_byte;
      rec.byte_offset  = off_r;
      rec.element_last = elast;
      if (elast) begin
        in_value_nxt = 1'b0;
        off_nxt      = '0;
      end else begin
        off_nxt = off_r + 32'd1;
      end
    end else begin
      if (hdr_cnt_r <= tlvp_pkg::HDR_TAG_LAST) begin
        tag_nxt = {tag_r[23:0], in_data.data_byte};
      end else begin
        len_nxt = {len_r[23:0], in_data.data_byte};
      end
      hdr_cnt_nxt = hdr_cnt_r + 1'b1;
      if (hdr_cnt_r == tlvp_pkg::HDR_LAST) begin
        hdr_cnt_nxt = '0;
        seen_nxt    = 1'b1;
        off_nxt     = '0;
        if (len_nxt == 32'd0) begin
          rec_v            = 1'b1;
          rec.kind         = tlvp_pkg::KIND_EMPTY;
          rec.tag          = tag_nxt;
          rec.element_last = 1'b1;
        end else begin
          in_value_nxt = 1'b1;
        end
      end
    end

    // Status record goes after any data record of the same item
    q_entry          = '0;
    q_entry.extra_ok = seen_nxt && !in_value_nxt;
    if (rec_v) begin
      q_entry.rec          = rec;
      q_entry.rec.run_last = !in_data.buffer_last;
      q_entry.extra_v      = in_data.buffer_last;
    end else begin
      q_entry.rec = tlvp_pkg::make_status(seen_nxt && !in_value_nxt);
    end
    q_push = accept && (rec_v || in_data.buffer_last);

    // Buffer end returns parse state to reset
    if (in_data.buffer_last) begin
      in_value_nxt = 1'b0;
      hdr_cnt_nxt  = '0;
      tag_nxt      = '0;
      len_nxt      = '0;
      off_nxt      = '0;
      seen_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_r <= 1'b0;
      hdr_cnt_r  <= '0;
      tag_r      <= '0;
      len_r      <= '0;
      off_r      <= '0;
      seen_r     <= 1'b0;
    end else if (accept) begin
      in_value_r <= in_value_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      tag_r      <= tag_nxt;
      len_r      <= len_nxt;
      off_r      <= off_nxt;
      seen_r     <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/tlvp_queue.sv */
// ----------------------------------------------------------------------------
// tlvp_queue
// Short FIFO of result entries between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvp_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  wire tlvp_pkg::tlvp_entry_t push_entry,
  output logic                  full,
  input  wire                   pop,
  output tlvp_pkg::tlvp_entry_t head_entry,
  output logic                  empty
);

  tlvp_pkg::tlvp_entry_t          entry_r [tlvp_pkg::QUEUE_DEPTH];
  logic [tlvp_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [tlvp_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [tlvp_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (cnt_r == tlvp_pkg::QCNT_W'(tlvp_pkg::QUEUE_DEPTH));
  assign empty      = (cnt_r == '0);
  assign head_entry = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* src/tlvp_back.sv */
// ----------------------------------------------------------------------------
// tlvp_back
// Drains queue entries into the output register, one result per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvp_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire tlvp_pkg::tlvp_entry_t head_entry,
  input  wire                   q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire                   out_stall,
  output tlvp_pkg::tlvp_out_t   out_data
);

  logic                out_valid_r, out_valid_nxt;
  tlvp_pkg::tlvp_out_t out_data_r, out_data_nxt;
  logic                sub_r, sub_nxt;   // 1: status half of head entry is next
  logic                load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sub_nxt       = sub_r;
    q_pop         = 1'b0;
    if (load) begin
      if (!q_empty) begin
        out_valid_nxt = 1'b1;
        if (sub_r) begin
          out_data_nxt = tlvp_pkg::make_status(head_entry.extra_ok);
          q_pop        = 1'b1;
          sub_nxt      = 1'b0;
        end else begin
          out_data_nxt = head_entry.rec;
          q_pop        = !head_entry.extra_v;
          sub_nxt      = head_entry.extra_v;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* src/tlv_stream_parser.sv */
// ----------------------------------------------------------------------------
// tlv_stream_parser
// Byte-serial TLV parser: 4-byte big-endian tag, 4-byte big-endian length,
// then the value bytes. Emits one record per value byte, one per empty
// element, and a pass/fail status record at the end of each buffer.
//
// Input channel (in_valid / in_stall / in_data): one buffer byte per item,
// buffer_last set on the final byte. Output channel (out_valid / out_stall /
// out_data): one result record per item; run_last marks the final record
// caused by an input byte. On a fail status the consumer drops the value
// bytes of the last, truncated element.
// Each record passes through the queue and then the output register. The
// input takes one byte per cycle while in_stall is low; a byte that
// causes two records (data plus status) is presented as two records in turn.
// A four-entry queue separates the parse front from the output register;
// in_stall rises only when that queue is full, so output stalls reach the
// input after the queue fills. Reset (rst_n low, synchronous) empties the
// queue, drops the output record and returns the parser to header state.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_stream_parser (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire tlvp_pkg::tlvp_in_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output tlvp_pkg::tlvp_out_t out_data
);

  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_empty;
  tlvp_pkg::tlvp_entry_t q_push_entry;
  tlvp_pkg::tlvp_entry_t q_head_entry;

  tlvp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_push_entry)
  );

  tlvp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_entry (q_head_entry),
    .empty      (q_empty)
  );

  tlvp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (q_head_entry),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV stream parser testbench
// Sends byte buffers through the parser: a short table of directed bytes for
// the edge cases, then random buffers built from well-formed tag/length/value
// elements with clean, truncated, short and padded endings. Both sides of
// the handshake idle at random. Every output record is checked field by
// field against an in-bench parse model or a typed record in the table.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned TARGET_ITEMS = 950;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef struct {
    tlvp_pkg::tlvp_in_t  item;
    bit                  typed;    // expected record typed in below, one record only
    tlvp_pkg::tlvp_out_t exp_rec;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tlvp_pkg::tlvp_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tlvp_pkg::tlvp_out_t out_data;

  // Parse state of the in-bench model
  bit          pr_in_value;
  int unsigned pr_hdr_cnt;
  logic [31:0] pr_tag;
  logic [31:0] pr_len;
  logic [31:0] pr_offset;
  bit          pr_seen;

  tlvp_pkg::tlvp_out_t step_recs[$];
  tlvp_pkg::tlvp_out_t expected_recs[$];
  tlvp_pkg::tlvp_in_t  stim_bytes[$];
  dir_row_t            dir_rows[$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned rx_wait = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  tlv_stream_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_parse();
    pr_in_value = 1'b0;
    pr_hdr_cnt  = 0;
    pr_tag      = '0;
    pr_len      = '0;
    pr_offset   = '0;
    pr_seen     = 1'b0;
  endfunction

  // Advance the parse state by one byte; the records it causes land in step_recs.
  function automatic void parse_byte(input tlvp_pkg::tlvp_in_t item);
    tlvp_pkg::tlvp_out_t r;
    step_recs.delete();
    if (pr_in_value) begin
      r              = '0;
      r.kind         = tlvp_pkg::KIND_VALUE;
      r.tag          = pr_tag;
      r.length       = pr_len;
      r.value_byte   = item.data_byte;
      r.byte_offset  = pr_offset;
      r.element_last = (pr_offset == pr_len - 32'd1);
      step_recs.insert(step_recs.size(), r);
      if (r.element_last) begin
        pr_in_value = 1'b0;
        pr_offset   = '0;
      end else begin
        pr_offset = pr_offset + 32'd1;
      end
    end else begin
      if (pr_hdr_cnt < 4)
        pr_tag = {pr_tag[23:0], item.data_byte};
      else
        pr_len = {pr_len[23:0], item.data_byte};
      pr_hdr_cnt++;
      if (pr_hdr_cnt == HDR_BYTES) begin
        pr_hdr_cnt = 0;
        pr_seen    = 1'b1;
        pr_offset  = '0;
        if (pr_len == '0) begin
          r              = '0;
          r.kind         = tlvp_pkg::KIND_EMPTY;
          r.tag          = pr_tag;
          r.element_last = 1'b1;
          step_recs.insert(step_recs.size(), r);
        end else begin
          pr_in_value = 1'b1;
        end
      end
    end
    if (item.buffer_last) begin
      r      = '0;
      r.kind = (pr_seen && !pr_in_value) ? tlvp_pkg::KIND_OK : tlvp_pkg::KIND_FAIL;
      step_recs.insert(step_recs.size(), r);
      clear_parse();
    end
    if (step_recs.size() > 0) begin
      r = step_recs.pop_back();
      r.run_last = 1'b1;
      step_recs.insert(step_recs.size(), r);
    end
  endfunction

  function automatic tlvp_pkg::tlvp_out_t mk_rec(input logic [1:0] kind,
                                                 input logic [31:0] tag,
                                                 input logic elast);
    tlvp_pkg::tlvp_out_t r;
    r              = '0;
    r.kind         = kind;
    r.tag          = tag;
    r.element_last = elast;
    r.run_last     = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic last, input bit typed,
                                  input tlvp_pkg::tlvp_out_t rec);
    dir_row_t row;
    row.item.data_byte   = b;
    row.item.buffer_last = last;
    row.typed            = typed;
    row.exp_rec          = rec;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    tlvp_pkg::tlvp_in_t it;
    it.data_byte   = b;
    it.buffer_last = 1'b0;
    stim_bytes.insert(stim_bytes.size(), it);
  endfunction

  function automatic void push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--)
      push_byte(w[i*8 +: 8]);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s: got %0h, expected %0h", cycles, what, got, want);
    errors++;
  endtask

  task automatic compare_record(input tlvp_pkg::tlvp_out_t got);
    tlvp_pkg::tlvp_out_t want;
    if (expected_recs.size() == 0) begin
      report_mismatch("record with nothing expected, kind", got.kind, '0);
    end else begin
      want = expected_recs.pop_front();
      if (got.kind != want.kind)
        report_mismatch("kind", got.kind, want.kind);
      if (got.tag != want.tag)
        report_mismatch("tag", got.tag, want.tag);
      if (got.length != want.length)
        report_mismatch("length", got.length, want.length);
      if (got.value_byte != want.value_byte)
        report_mismatch("value_byte", got.value_byte, want.value_byte);
      if (got.byte_offset != want.byte_offset)
        report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
      if (got.element_last != want.element_last)
        report_mismatch("element_last", got.element_last, want.element_last);
      if (got.run_last != want.run_last)
        report_mismatch("run_last", got.run_last, want.run_last);
    end
  endtask

  task automatic send_item(input tlvp_pkg::tlvp_in_t item, input bit typed,
                           input tlvp_pkg::tlvp_out_t rec);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    parse_byte(item);
    if (typed)
      expected_recs.insert(expected_recs.size(), rec);
    else
      foreach (step_recs[i]) expected_recs.insert(expected_recs.size(), step_recs[i]);
    items_sent++;
  endtask

  // Random buffer: well-formed elements, then a clean end, a padded end,
  // a truncated value or noise. One in ten is a short buffer.
  task automatic build_buffer();
    int unsigned        n_elem;
    int unsigned        vlen;
    int unsigned        k;
    logic [31:0]        len;
    tlvp_pkg::tlvp_in_t it;
    stim_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(1, HDR_BYTES - 1);
      repeat (k) push_byte($urandom_range(0, 255));
    end else begin
      n_elem = $urandom_range(1, 4);
      repeat (n_elem) begin
        vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        push_word($urandom);
        push_word(vlen);
        repeat (vlen) push_byte($urandom_range(0, 255));
      end
      case ($urandom_range(0, 7))
        5: begin
          k = $urandom_range(1, HDR_BYTES - 1);
          repeat (k) push_byte($urandom_range(0, 255));
        end
        6: begin
          // length always above the bytes that follow, so the value is cut off
          len = $urandom | 32'h8;
          push_word($urandom);
          push_word(len);
          k = $urandom_range(0, 5);
          repeat (k) push_byte($urandom_range(0, 255));
        end
        7: begin
          k = $urandom_range(1, 12);
          repeat (k) push_byte($urandom_range(0, 255));
        end
        default: ;
      endcase
    end
    it = stim_bytes.pop_back();
    it.buffer_last = 1'b1;
    stim_bytes.insert(stim_bytes.size(), it);
  endtask

  // Output side: random stall after each accepted record
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        compare_record(out_data);
        rx_wait = rx_idle_on ? $urandom_range(0, 14) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clear_parse();

    // short buffer: one byte, no header
    add_row(8'h00, 1'b1, 1'b1, mk_rec(tlvp_pkg::KIND_FAIL, '0, 1'b0));
    // empty element, all-ones tag
    for (int i = 0; i < 4; i++) add_row(8'hFF, 1'b0, 1'b0, '0);
    for (int i = 0; i < 3; i++) add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, mk_rec(tlvp_pkg::KIND_EMPTY, 32'hFFFF_FFFF, 1'b1));
    // one stray header byte after a complete element still passes
    add_row(8'h5A, 1'b1, 1'b1, mk_rec(tlvp_pkg::KIND_OK, '0, 1'b0));
    // zero tag, all-ones length, cut off after the first value byte
    for (int i = 0; i < 4; i++) add_row(8'h00, 1'b0, 1'b0, '0);
    for (int i = 0; i < 4; i++) add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].exp_rec);

    while (items_sent < TARGET_ITEMS) begin
      build_buffer();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      foreach (stim_bytes[i])
        send_item(stim_bytes[i], 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_recs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
